// ===== hw/rtl/derenc_pkg.sv =====
package derenc_pkg;

  localparam int unsigned LOW_TAG_MAX   = 30;
  localparam int unsigned SHORT_LEN_MAX = 127;
  localparam logic [7:0]  CONSTRUCTED_BIT = 8'h20;
  localparam logic [7:0]  HIGH_TAG_MARK   = 8'h1F;
  localparam logic [7:0]  LONG_LEN_MARK   = 8'h80;
  localparam logic [7:0]  CONT_BIT        = 8'h80;
  localparam int unsigned OCTET_BITS      = 8;

  typedef logic [2:0] octet_idx_t;

  typedef struct packed {
    logic [1:0]  tag_class;
    logic        constructed;
    logic [31:0] tag_number;
    logic [31:0] contents_length;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [32:0] total_length;
  } result_t;

  typedef struct packed {
    logic [7:0]  id_octet;
    logic        high_tag;
    logic [31:0] tag_number;
    octet_idx_t  tag_top;
    logic        long_len;
    logic [7:0]  len_octet;
    octet_idx_t  len_top;
    logic [31:0] contents_length;
    logic [32:0] total_length;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_TAG,
    PH_LEN,
    PH_LEN_BYTES
  } phase_t;

endpackage

// ===== hw/rtl/derenc_front.sv =====
module derenc_front
  import derenc_pkg::*;
(
  input  logic        start,
  input  item_t       item,
  input  queue_stat_t stat,
  output logic        busy,
  output logic        push,
  output entry_t      entry
);

  logic [7:0] first;
  logic [3:0] hdr_len;

  assign busy = stat.full;
  assign push = start && !stat.full;

  always_comb begin
    first = {item.tag_class, 6'b0} | (item.constructed ? CONSTRUCTED_BIT : 8'h00);

    entry                 = '0;
    entry.tag_number      = item.tag_number;
    entry.contents_length = item.contents_length;
    entry.high_tag        = item.tag_number > 32'(LOW_TAG_MAX);
    entry.long_len        = item.contents_length > 32'(SHORT_LEN_MAX);

    if (entry.high_tag) begin
      entry.id_octet = first | HIGH_TAG_MARK;
    end else begin
      entry.id_octet = first | {3'b0, item.tag_number[4:0]};
    end

    if (item.tag_number[31:28] != '0) begin
      entry.tag_top = 3'd4;
    end else if (item.tag_number[31:21] != '0) begin
      entry.tag_top = 3'd3;
    end else if (item.tag_number[31:14] != '0) begin
      entry.tag_top = 3'd2;
    end else if (item.tag_number[31:7] != '0) begin
      entry.tag_top = 3'd1;
    end else begin
      entry.tag_top = 3'd0;
    end

    if (item.contents_length[31:24] != '0) begin
      entry.len_top = 3'd3;
    end else if (item.contents_length[31:16] != '0) begin
      entry.len_top = 3'd2;
    end else if (item.contents_length[31:8] != '0) begin
      entry.len_top = 3'd1;
    end else begin
      entry.len_top = 3'd0;
    end

    if (entry.long_len) begin
      entry.len_octet = LONG_LEN_MARK | {5'b0, entry.len_top + 3'd1};
    end else begin
      entry.len_octet = item.contents_length[7:0];
    end

    hdr_len = 4'd2
            + (entry.high_tag ? {1'b0, entry.tag_top} + 4'd1 : 4'd0)
            + (entry.long_len ? {1'b0, entry.len_top} + 4'd1 : 4'd0);
    entry.total_length = {29'b0, hdr_len} + {1'b0, item.contents_length};
  end

endmodule

// ===== hw/rtl/derenc_queue.sv =====
module derenc_queue
  import derenc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      wdata,
  input  logic        pop,
  output entry_t      rdata,
  output queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = count == CNT_W'(DEPTH);
  assign stat.empty = count == '0;
  assign rdata      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/derenc_back.sv =====
module derenc_back
  import derenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      entry,
  input  queue_stat_t stat,
  output logic        pop,
  output logic        strobe,
  output result_t     result
);

  phase_t     state;
  phase_t     state_next;
  octet_idx_t idx;
  octet_idx_t idx_next;
  entry_t     cur;
  logic       last_now;
  logic [7:0] tag_group;
  logic [7:0] len_byte;

  always_comb begin
    case (idx)
      3'd0:    tag_group = {1'b0, cur.tag_number[6:0]};
      3'd1:    tag_group = {1'b0, cur.tag_number[13:7]};
      3'd2:    tag_group = {1'b0, cur.tag_number[20:14]};
      3'd3:    tag_group = {1'b0, cur.tag_number[27:21]};
      3'd4:    tag_group = {4'b0, cur.tag_number[31:28]};
      default: tag_group = '0;
    endcase
    if (idx != '0) begin
      tag_group = tag_group | CONT_BIT;
    end
    case (idx)
      3'd0:    len_byte = cur.contents_length[7:0];
      3'd1:    len_byte = cur.contents_length[15:8];
      3'd2:    len_byte = cur.contents_length[23:16];
      3'd3:    len_byte = cur.contents_length[31:24];
      default: len_byte = '0;
    endcase
  end

  // outputs
  always_comb begin
    result   = '0;
    last_now = 1'b0;
    strobe   = state != PH_IDLE;
    case (state)
      PH_ID:        result.out_byte = cur.id_octet;
      PH_TAG:       result.out_byte = tag_group;
      PH_LEN: begin
        result.out_byte = cur.len_octet;
        last_now        = !cur.long_len;
      end
      PH_LEN_BYTES: begin
        result.out_byte = len_byte;
        last_now        = idx == '0;
      end
      default:      result.out_byte = '0;
    endcase
    result.last = last_now;
    if (last_now) begin
      result.total_length = cur.total_length;
    end
    pop = (state == PH_IDLE || last_now) && !stat.empty;
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    if (pop) begin
      state_next = PH_ID;
    end else if (last_now) begin
      state_next = PH_IDLE;
    end else begin
      case (state)
        PH_ID: begin
          if (cur.high_tag) begin
            state_next = PH_TAG;
            idx_next   = cur.tag_top;
          end else begin
            state_next = PH_LEN;
          end
        end
        PH_TAG: begin
          if (idx == '0) begin
            state_next = PH_LEN;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
        PH_LEN: begin
          state_next = PH_LEN_BYTES;
          idx_next   = cur.len_top;
        end
        PH_LEN_BYTES: idx_next = idx - 1'b1;
        default:      state_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== hw/rtl/der_tag_length_header_encoder.sv =====
// Path: with the serializer idle, an accepted transaction is written into the queue, then popped into
// the serializer's entry and state registers, which put its first octet on the result port.
// Throughput: 2 to 11 octets per transaction, one per cycle, set by the serializer;
// queued transactions follow each other with no gap.
// busy rises when the QUEUE_DEPTH-entry queue between classifier and serializer is full.
// Reset (synchronous, active high) empties the queue and idles the serializer.
// The receiver cannot stall: each octet is on the result port for exactly one cycle.
module der_tag_length_header_encoder
  import derenc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    strobe,
  output result_t result
);

  queue_stat_t stat;
  entry_t      wdata;
  entry_t      rdata;
  logic        push;
  logic        pop;

  derenc_front u_front (
    .start (start),
    .item  (item),
    .stat  (stat),
    .busy  (busy),
    .push  (push),
    .entry (wdata)
  );

  derenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (stat)
  );

  derenc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (rdata),
    .stat   (stat),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== hw/rtl/derenc_checker.sv =====
module derenc_checker
  import derenc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  a_total_only_on_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.total_length == '0)
    else $error("total length shown before last octet");

  a_total_min: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> result.total_length >= 33'd2)
    else $error("total length below header minimum");

  a_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> !result.last)
    else $error("last flagged without strobe");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("octet emitted right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy right after reset");

endmodule

bind der_tag_length_header_encoder derenc_checker u_derenc_checker (.*);

// ===== sim/der_tag_length_header_encoder_test.sv =====
module der_tag_length_header_encoder_test;
  import derenc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    strobe;
  result_t result;

  result_t expected_octets[$];
  int      octet_errors = 0;
  bit      sender_idles = 1'b1;

  der_tag_length_header_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void predict_header(input item_t h);
    logic [7:0]  octs [0:10];
    logic [7:0]  ident;
    logic [7:0]  g;
    logic [32:0] total;
    result_t     r;
    int          n;
    int          groups;
    int          nbytes;
    int          i;
    n = 0;
    ident = {h.tag_class, 6'b0};
    if (h.constructed) begin
      ident = ident | CONSTRUCTED_BIT;
    end
    if (h.tag_number <= LOW_TAG_MAX) begin
      octs[n] = ident | h.tag_number[7:0];
      n = n + 1;
    end else begin
      octs[n] = ident | HIGH_TAG_MARK;
      n = n + 1;
      groups = 1;
      while (groups < 5 && (h.tag_number >> (7 * groups)) != 0) begin
        groups = groups + 1;
      end
      for (i = groups - 1; i >= 0; i--) begin
        g = 8'(h.tag_number >> (7 * i)) & 8'h7F;
        if (i != 0) begin
          g = g | CONT_BIT;
        end
        octs[n] = g;
        n = n + 1;
      end
    end
    if (h.contents_length <= SHORT_LEN_MAX) begin
      octs[n] = h.contents_length[7:0];
      n = n + 1;
    end else begin
      nbytes = 1;
      while (nbytes < 4 && (h.contents_length >> (OCTET_BITS * nbytes)) != 0) begin
        nbytes = nbytes + 1;
      end
      octs[n] = LONG_LEN_MARK | 8'(nbytes);
      n = n + 1;
      for (i = nbytes - 1; i >= 0; i--) begin
        octs[n] = 8'(h.contents_length >> (OCTET_BITS * i));
        n = n + 1;
      end
    end
    total = 33'(n) + 33'(h.contents_length);
    for (i = 0; i < n; i++) begin
      r.out_byte     = octs[i];
      r.last         = (i == n - 1);
      r.total_length = (i == n - 1) ? total : 33'd0;
      expected_octets.push_back(r);
    end
  endfunction

  function automatic item_t make_header(input logic [1:0] cls, input logic cons,
                                        input logic [31:0] tag, input logic [31:0] len);
    item_t h;
    h.tag_class       = cls;
    h.constructed     = cons;
    h.tag_number      = tag;
    h.contents_length = len;
    return h;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!sender_idles) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_header(input item_t h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= h;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predict_header(h);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_octets.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_magnitude();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = $urandom_range(120, 300);
      2: v = $urandom;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (expected_octets.size() == 0) begin
        octet_errors++;
        if (octet_errors <= 10) begin
          $display("unexpected octet: byte=%02h last=%0b total=%0d",
                   result.out_byte, result.last, result.total_length);
        end
      end else begin
        want = expected_octets.pop_front();
        if (result.out_byte !== want.out_byte || result.last !== want.last ||
            result.total_length !== want.total_length) begin
          octet_errors++;
          if (octet_errors <= 10) begin
            $display({"octet mismatch: expected byte=%02h last=%0b total=%0d, ",
                      "got byte=%02h last=%0b total=%0d"},
                     want.out_byte, want.last, want.total_length,
                     result.out_byte, result.last, result.total_length);
          end
        end
      end
    end
  end

  task automatic test_low_tags();
    int cls;
    for (cls = 0; cls < 4; cls++) begin
      send_header(make_header(2'(cls), cls[0], 32'd0, 32'd0));
      send_header(make_header(2'(cls), ~cls[0], 32'd30, 32'd127));
    end
  endtask

  task automatic test_high_tags();
    send_header(make_header(2'd0, 1'b0, 32'd31, 32'd5));
    send_header(make_header(2'd1, 1'b1, 32'd127, 32'd1));
    send_header(make_header(2'd2, 1'b0, 32'd128, 32'd64));
    send_header(make_header(2'd3, 1'b1, 32'd16383, 32'd100));
    send_header(make_header(2'd0, 1'b1, 32'd16384, 32'd0));
    send_header(make_header(2'd1, 1'b0, 32'h001F_FFFF, 32'd127));
    send_header(make_header(2'd2, 1'b1, 32'h1000_0000, 32'd9));
    send_header(make_header(2'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_long_lengths();
    send_header(make_header(2'd0, 1'b0, 32'd2, 32'd128));
    send_header(make_header(2'd1, 1'b0, 32'd16, 32'd255));
    send_header(make_header(2'd2, 1'b1, 32'd4, 32'd256));
    send_header(make_header(2'd3, 1'b0, 32'd12, 32'h0000_FFFF));
    send_header(make_header(2'd0, 1'b1, 32'd48, 32'h0001_0000));
    send_header(make_header(2'd1, 1'b1, 32'd1, 32'h00FF_FFFF));
    send_header(make_header(2'd2, 1'b0, 32'd3, 32'h0100_0000));
    send_header(make_header(2'd3, 1'b0, 32'd20, 32'hFFFF_FFFF));
  endtask

  task automatic test_drain_pause();
    send_header(make_header(2'd2, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000));
    send_header(make_header(2'd1, 1'b0, 32'd7, 32'd3));
    wait_drained();
    send_header(make_header(2'd0, 1'b0, 32'd31, 32'd128));
  endtask

  task automatic test_random_headers();
    int k;
    for (k = 0; k < 290; k++) begin
      if (k % 30 == 0) begin
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      if (k == 150) begin
        wait_drained();
      end
      send_header(make_header(2'($urandom), 1'($urandom), random_magnitude(),
                              random_magnitude()));
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_low_tags();
    test_high_tags();
    test_long_lengths();
    test_drain_pause();
    test_random_headers();
    wait_drained();
    repeat (20) @(posedge clk);
    if (octet_errors == 0 && expected_octets.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
